@@ rtl/qhp_pkg.sv @@
// shared types and constants for the quic header parser
// used by qhp_parse and quic_header_parser; no dependencies
package qhp_pkg;

  localparam int unsigned PosW = 16;
  localparam logic [PosW-1:0] MaxDatagramBytes = 16'd65535;
  localparam logic [PosW-1:0] LongMinBytes = 16'd7;
  localparam logic [4:0] CidMax = 5'd20;
  localparam logic [4:0] ShortDcidReset = 5'd8;
  localparam logic [7:0] VersionBytes = 8'd4;

  // one-hot parse phase
  typedef enum logic [8:0] {
    PH_FIRST    = 9'b000000001,
    PH_VERSION  = 9'b000000010,
    PH_DCID_LEN = 9'b000000100,
    PH_DCID     = 9'b000001000,
    PH_SCID_LEN = 9'b000010000,
    PH_SCID     = 9'b000100000,
    PH_TOKLEN   = 9'b001000000,
    PH_TOKEN    = 9'b010000000,
    PH_BODY     = 9'b100000000
  } phase_e;

  typedef enum logic [3:0] {
    CLS_FIRST    = 4'd0,
    CLS_VERSION  = 4'd1,
    CLS_DCID_LEN = 4'd2,
    CLS_DCID     = 4'd3,
    CLS_SCID_LEN = 4'd4,
    CLS_SCID     = 4'd5,
    CLS_TOKLEN   = 4'd6,
    CLS_TOKEN    = 4'd7,
    CLS_BODY     = 4'd8,
    CLS_IGNORED  = 4'd9
  } byte_class_e;

  typedef enum logic [2:0] {
    ST_PENDING     = 3'd0,
    ST_OK          = 3'd1,
    ST_LONG_SHORT  = 3'd2,
    ST_CID_TRUNC   = 3'd3,
    ST_TOKEN_TRUNC = 3'd4
  } parse_status_e;

  // one result word
  typedef struct packed {
    byte_class_e   byte_class;
    logic [7:0]    byte_echo;
    logic          end_of_packet;
    parse_status_e parse_status;
    logic          long_form;
    logic [7:0]    header_first_byte;
    logic [31:0]   version_word;
    logic [7:0]    dest_cid_length;
    logic [7:0]    src_cid_length;
    logic [9:0]    header_bytes;
    logic [61:0]   token_bytes;
  } result_t;

endpackage

@@ rtl/qhp_parse.sv @@
// header parse state and per-byte next-state logic
// depends on qhp_pkg; produces the result word for the byte being accepted
module qhp_parse import qhp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_value_i,
  input  logic       is_last_i,
  input  logic [4:0] sdcid_cfg_i,
  output result_t    result_o
);

  logic [PosW-1:0] pos_q, pos_d;
  phase_e          phase_q, phase_d;
  logic [7:0]      first_q, first_d;
  logic [31:0]     ver_q, ver_d;
  logic [7:0]      dcid_q, dcid_d;
  logic [7:0]      scid_q, scid_d;
  logic [7:0]      field_q, field_d;
  logic [61:0]     vacc_q, vacc_d;
  logic [2:0]      vleft_q, vleft_d;
  logic [61:0]     tok_q, tok_d;
  logic [9:0]      hlen_q, hlen_d;

  logic [4:0]      sdcid;
  byte_class_e     cls;
  logic            lng;
  logic            initial_pkt;
  logic [7:0]      b;

  assign b = byte_value_i;
  assign sdcid = (sdcid_cfg_i > CidMax) ? CidMax : sdcid_cfg_i;

  always_comb begin
    pos_d   = pos_q;
    phase_d = phase_q;
    first_d = first_q;
    ver_d   = ver_q;
    dcid_d  = dcid_q;
    scid_d  = scid_q;
    field_d = field_q;
    vacc_d  = vacc_q;
    vleft_d = vleft_q;
    tok_d   = tok_q;
    hlen_d  = hlen_q;
    cls     = CLS_IGNORED;

    if (pos_q < MaxDatagramBytes) begin
      pos_d = pos_q + 16'd1;
      unique case (phase_q)
        PH_FIRST: begin
          cls = CLS_FIRST;
          first_d = b;
          if (b[7]) begin
            field_d = VersionBytes;
            phase_d = PH_VERSION;
          end else begin
            dcid_d  = {3'b000, sdcid};
            field_d = {3'b000, sdcid};
            if (sdcid == 5'd0) begin
              hlen_d  = 10'd1;
              phase_d = PH_BODY;
            end else begin
              phase_d = PH_DCID;
            end
          end
        end
        PH_VERSION: begin
          cls = CLS_VERSION;
          ver_d = {ver_q[23:0], b};
          field_d = field_q - 8'd1;
          if (field_d == 8'd0) phase_d = PH_DCID_LEN;
        end
        PH_DCID_LEN: begin
          cls = CLS_DCID_LEN;
          dcid_d  = b;
          field_d = b;
          phase_d = (b != 8'd0) ? PH_DCID : PH_SCID_LEN;
        end
        PH_DCID: begin
          cls = CLS_DCID;
          field_d = field_q - 8'd1;
          if (field_d == 8'd0) begin
            if (first_q[7]) begin
              phase_d = PH_SCID_LEN;
            end else begin
              hlen_d  = 10'd1 + {2'b00, dcid_q};
              phase_d = PH_BODY;
            end
          end
        end
        PH_SCID_LEN: begin
          cls = CLS_SCID_LEN;
          scid_d  = b;
          field_d = b;
          if (b == 8'd0) begin
            hlen_d  = 10'(LongMinBytes) + {2'b00, dcid_q};
            vacc_d  = '0;
            vleft_d = '0;
            phase_d = (first_q[5:4] == 2'b00) ? PH_TOKLEN : PH_BODY;
          end else begin
            phase_d = PH_SCID;
          end
        end
        PH_SCID: begin
          cls = CLS_SCID;
          field_d = field_q - 8'd1;
          if (field_d == 8'd0) begin
            hlen_d  = 10'(LongMinBytes) + {2'b00, dcid_q} + {2'b00, scid_q};
            vacc_d  = '0;
            vleft_d = '0;
            phase_d = (first_q[5:4] == 2'b00) ? PH_TOKLEN : PH_BODY;
          end
        end
        PH_TOKLEN: begin
          cls = CLS_TOKLEN;
          if (vleft_q == 3'd0) begin
            vacc_d  = {56'd0, b[5:0]};
            // prefix 00/01/10/11 gives 0/1/3/7 more bytes
            vleft_d = 3'((4'd1 << b[7:6]) - 4'd1);
          end else begin
            vacc_d  = {vacc_q[53:0], b};
            vleft_d = vleft_q - 3'd1;
          end
          if (vleft_d == 3'd0) begin
            tok_d   = vacc_d;
            phase_d = (vacc_d != 62'd0) ? PH_TOKEN : PH_BODY;
          end
        end
        PH_TOKEN: begin
          cls = CLS_TOKEN;
          tok_d = tok_q - 62'd1;
          if (tok_d == 62'd0) phase_d = PH_BODY;
        end
        default: begin
          cls = CLS_BODY;
          phase_d = PH_BODY;
        end
      endcase
    end
  end

  assign lng = first_d[7];
  assign initial_pkt = lng && (first_d[5:4] == 2'b00);

  always_comb begin
    result_o = '0;
    result_o.byte_class    = cls;
    result_o.byte_echo     = b;
    result_o.end_of_packet = is_last_i;
    result_o.parse_status  = ST_PENDING;
    if (is_last_i) begin
      priority if (lng && (pos_d < LongMinBytes)) begin
        result_o.parse_status = ST_LONG_SHORT;
      end else if ((phase_d == PH_FIRST) || (phase_d == PH_VERSION) ||
                   (phase_d == PH_DCID_LEN) || (phase_d == PH_DCID) ||
                   (phase_d == PH_SCID_LEN) || (phase_d == PH_SCID)) begin
        result_o.parse_status = ST_CID_TRUNC;
      end else if ((phase_d == PH_TOKLEN) || (phase_d == PH_TOKEN)) begin
        result_o.parse_status = ST_TOKEN_TRUNC;
      end else begin
        result_o.parse_status = ST_OK;
      end
      result_o.long_form         = lng;
      result_o.header_first_byte = first_d;
      result_o.version_word      = lng ? ver_d : 32'd0;
      result_o.dest_cid_length   = dcid_d;
      result_o.src_cid_length    = lng ? scid_d : 8'd0;
      result_o.header_bytes      = hlen_d;
      result_o.token_bytes       =
        (initial_pkt && ((phase_d == PH_TOKEN) || (phase_d == PH_BODY))) ? vacc_d : 62'd0;
    end
  end

  // the last byte of a datagram returns the parser to its reset state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= PH_FIRST;
      first_q <= '0;
      ver_q   <= '0;
      dcid_q  <= '0;
      scid_q  <= '0;
      field_q <= '0;
      vacc_q  <= '0;
      vleft_q <= '0;
      tok_q   <= '0;
      hlen_q  <= '0;
    end else if (accept_i) begin
      if (is_last_i) begin
        pos_q   <= '0;
        phase_q <= PH_FIRST;
        first_q <= '0;
        ver_q   <= '0;
        dcid_q  <= '0;
        scid_q  <= '0;
        field_q <= '0;
        vacc_q  <= '0;
        vleft_q <= '0;
        tok_q   <= '0;
        hlen_q  <= '0;
      end else begin
        pos_q   <= pos_d;
        phase_q <= phase_d;
        first_q <= first_d;
        ver_q   <= ver_d;
        dcid_q  <= dcid_d;
        scid_q  <= scid_d;
        field_q <= field_d;
        vacc_q  <= vacc_d;
        vleft_q <= vleft_d;
        tok_q   <= tok_d;
        hlen_q  <= hlen_d;
      end
    end
  end

endmodule

@@ rtl/quic_header_parser.sv @@
// top level of the quic v1 packet header parser
// depends on qhp_pkg and qhp_parse; holds the config register and output buffering
//
// Takes one datagram byte per cycle and returns one tagged word per byte, registered
// after the byte is accepted, in an output register backed by a one-word skid buffer,
// so a new byte is taken every cycle while the output side keeps up. The parse state
// lives in qhp_parse and is updated in the same cycle a byte is accepted. The word
// for the byte flagged last carries the status and header summary, and the parser
// then starts over for the next datagram. The short-header dcid length is written
// through the config channel, which is always ready, and is sampled when a first
// byte arrives.
module quic_header_parser import qhp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  short_cid_bytes_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_value_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  byte_class_o,
  output logic [7:0]  byte_echo_o,
  output logic        end_of_packet_o,
  output logic [2:0]  parse_status_o,
  output logic        long_form_o,
  output logic [7:0]  header_first_byte_o,
  output logic [31:0] version_word_o,
  output logic [7:0]  dest_cid_length_o,
  output logic [7:0]  src_cid_length_o,
  output logic [9:0]  header_bytes_o,
  output logic [61:0] token_bytes_o
);

  logic [4:0] sdcid_q;
  logic       in_fire;
  logic       out_take;
  result_t    res;
  result_t    out_q, out_d;
  result_t    skid_q, skid_d;
  logic       out_valid_q, out_valid_d;
  logic       skid_valid_q, skid_valid_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sdcid_q <= ShortDcidReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      sdcid_q <= short_cid_bytes_i;
    end
  end

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign out_take   = out_valid_q && !out_stall_i;

  qhp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_fire),
    .byte_value_i (byte_value_i),
    .is_last_i    (is_last_i),
    .sdcid_cfg_i  (sdcid_q),
    .result_o     (res)
  );

  // output register with a one-word skid behind it
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_take || !out_valid_q) begin
      out_valid_d  = skid_valid_q || in_fire;
      out_d        = skid_valid_q ? skid_q : res;
      skid_valid_d = 1'b0;
    end else if (in_fire) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o         = out_valid_q;
  assign byte_class_o        = out_q.byte_class;
  assign byte_echo_o         = out_q.byte_echo;
  assign end_of_packet_o     = out_q.end_of_packet;
  assign parse_status_o      = out_q.parse_status;
  assign long_form_o         = out_q.long_form;
  assign header_first_byte_o = out_q.header_first_byte;
  assign version_word_o      = out_q.version_word;
  assign dest_cid_length_o   = out_q.dest_cid_length;
  assign src_cid_length_o    = out_q.src_cid_length;
  assign header_bytes_o      = out_q.header_bytes;
  assign token_bytes_o       = out_q.token_bytes;

endmodule
